// ===== sv/ect_pkg.sv =====
`default_nettype none

package ect_pkg;

    // fixed field widths
    localparam int OUT_IDX_W = 6;
    localparam int MARGIN_W  = 20;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONVEX_MARGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_MARGIN = 2'd1;

    typedef logic [OUT_IDX_W-1:0] t_idx;

    // operand triple of the cross product unit
    typedef enum logic [2:0] {XS_AREA, XS_ABC, XS_ABP, XS_BCP, XS_CAP} t_xsel;

    // vertex store read address source
    typedef enum logic [2:0] {AS_CTRL, AS_I0, AS_I1, AS_I2, AS_P} t_asel;

    // destination of vertex store read data
    typedef enum logic [2:0] {CD_NONE, CD_A, CD_B, CD_C, CD_P} t_cdst;

    // destination of working list read data
    typedef enum logic [2:0] {RD_NONE, RD_I0, RD_I1, RD_I2, RD_P} t_rdst;

    typedef struct packed {
        logic  st_we;
        t_asel st_asel;
        t_idx  ctrl_addr;
        t_cdst cdst;
        logic  x_start;
        t_xsel xsel;
        logic  area_clr;
        logic  area_acc;
        logic  rl_we;
        logic  rl_wsrc;
        t_idx  rl_waddr;
        t_idx  rl_wdata;
        t_idx  rl_raddr;
        t_rdst rdst;
        logic  tb_we;
        t_idx  tb_addr;
        logic  out_load;
        logic  out_fan;
        t_idx  fan_a;
        t_idx  fan_b;
        t_idx  fan_c;
        logic  out_last;
        logic  out_trunc;
    } t_cmd;

    typedef struct packed {
        logic x_done;
        logic gt_convex;
        logic gt_inside;
        logic area_neg;
        logic p_is_corner;
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/ect_vtx_if.sv =====
`default_nettype none

interface ect_vtx_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic                          last_vertex;

    modport source (output valid, output coord_x, output coord_y, output last_vertex,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input last_vertex,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/ect_tri_if.sv =====
`default_nettype none

interface ect_tri_if;
    import ect_pkg::*;

    logic valid;
    logic ready;
    t_idx corner_a;
    t_idx corner_b;
    t_idx corner_c;
    logic last_triangle;
    logic used_fan;
    logic truncated;

    modport source (output valid, output corner_a, output corner_b, output corner_c,
                    output last_triangle, output used_fan, output truncated, input ready);
    modport sink   (input valid, input corner_a, input corner_b, input corner_c,
                    input last_triangle, input used_fan, input truncated, output ready);
endinterface

`default_nettype wire

// ===== sv/ect_datapath.sv =====
`default_nettype none

module ect_datapath #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ect_pkg::t_cmd                 i_cmd,
    output ect_pkg::t_sts                      o_sts,
    input  wire logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  wire logic [ect_pkg::MARGIN_W-1:0]  i_convex_margin,
    input  wire logic [ect_pkg::MARGIN_W-1:0]  i_inside_margin,
    output ect_pkg::t_idx                      o_corner_a,
    output ect_pkg::t_idx                      o_corner_b,
    output ect_pkg::t_idx                      o_corner_c,
    output logic                               o_last_triangle,
    output logic                               o_used_fan,
    output logic                               o_truncated
);
    import ect_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int IW   = $clog2(MAX_VERTICES);
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int XW   = PW + 1;
    localparam int AW   = XW + IW;
    localparam int CMPW = XW + MARGIN_W;

    // vertex store, working list and triangle buffer
    logic [2*CW-1:0] r_st_mem [MAX_VERTICES];
    logic [IW-1:0]   r_rl_mem [MAX_VERTICES];
    logic [3*IW-1:0] r_tb_mem [MAX_VERTICES];
    logic [2*CW-1:0] r_st_rd;
    logic [IW-1:0]   r_rl_rd;
    logic [3*IW-1:0] r_tb_rd;
    t_cdst           r_cdst;
    t_rdst           r_rdst;

    logic [IW-1:0] r_i0, r_i1, r_i2, r_ip;
    logic signed [CW-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_px, r_py;

    logic [IW-1:0] w_st_raddr;
    logic [IW-1:0] w_rl_wdata;

    // cross product pipeline
    logic signed [CW-1:0] w_ux, w_uy, w_vx, w_vy, w_wx, w_wy;
    logic signed [DW-1:0] r_dvx, r_dvy, r_dwx, r_dwy;
    logic signed [PW-1:0] r_p, r_q;
    logic signed [XW-1:0] r_cross;
    logic signed [AW-1:0] r_area;
    logic [2:0]           r_vld;
    logic signed [CMPW-1:0] w_cross_ext, w_cvx_ext, w_ins_ext;

    // store read address select
    always_comb begin
        case (i_cmd.st_asel)
            AS_I0:   w_st_raddr = r_i0;
            AS_I1:   w_st_raddr = r_i1;
            AS_I2:   w_st_raddr = r_i2;
            AS_P:    w_st_raddr = r_ip;
            default: w_st_raddr = i_cmd.ctrl_addr[IW-1:0];
        endcase
    end

    assign w_rl_wdata = i_cmd.rl_wsrc ? r_rl_rd : i_cmd.rl_wdata[IW-1:0];

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.st_we) begin
            r_st_mem[i_cmd.ctrl_addr[IW-1:0]] <= {i_coord_x, i_coord_y};
        end
        r_st_rd <= r_st_mem[w_st_raddr];
        if (i_cmd.rl_we) begin
            r_rl_mem[i_cmd.rl_waddr[IW-1:0]] <= w_rl_wdata;
        end
        r_rl_rd <= r_rl_mem[i_cmd.rl_raddr[IW-1:0]];
        if (i_cmd.tb_we) begin
            r_tb_mem[i_cmd.tb_addr[IW-1:0]] <= {r_i0, r_i1, r_i2};
        end
        r_tb_rd <= r_tb_mem[i_cmd.tb_addr[IW-1:0]];
    end

    // read destinations are registered alongside the memory reads so that they line up with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cdst <= CD_NONE;
            r_rdst <= RD_NONE;
            r_vld  <= '0;
        end else begin
            r_cdst <= i_cmd.cdst;
            r_rdst <= i_cmd.rdst;
            r_vld  <= {r_vld[1:0], i_cmd.x_start};
        end
    end

    // coordinate and index registers
    always_ff @(posedge i_clk) begin
        case (r_cdst)
            CD_A:    {r_ax, r_ay} <= r_st_rd;
            CD_B:    {r_bx, r_by} <= r_st_rd;
            CD_C:    {r_cx, r_cy} <= r_st_rd;
            CD_P:    {r_px, r_py} <= r_st_rd;
            default: ;
        endcase
        case (r_rdst)
            RD_I0:   r_i0 <= r_rl_rd;
            RD_I1:   r_i1 <= r_rl_rd;
            RD_I2:   r_i2 <= r_rl_rd;
            RD_P:    r_ip <= r_rl_rd;
            default: ;
        endcase
    end

    // operand triple select
    always_comb begin
        w_ux = r_ax; w_uy = r_ay;
        w_vx = r_bx; w_vy = r_by;
        w_wx = r_cx; w_wy = r_cy;
        case (i_cmd.xsel)
            XS_AREA: begin
                w_ux = '0;   w_uy = '0;
            end
            XS_ABP: begin
                w_wx = r_px; w_wy = r_py;
            end
            XS_BCP: begin
                w_ux = r_bx; w_uy = r_by;
                w_vx = r_cx; w_vy = r_cy;
                w_wx = r_px; w_wy = r_py;
            end
            XS_CAP: begin
                w_ux = r_cx; w_uy = r_cy;
                w_vx = r_ax; w_vy = r_ay;
                w_wx = r_px; w_wy = r_py;
            end
            default: ;
        endcase
    end

    // differences, products, cross and area accumulation
    always_ff @(posedge i_clk) begin
        r_dvx   <= DW'(w_vx) - DW'(w_ux);
        r_dvy   <= DW'(w_vy) - DW'(w_uy);
        r_dwx   <= DW'(w_wx) - DW'(w_ux);
        r_dwy   <= DW'(w_wy) - DW'(w_uy);
        r_p     <= r_dvx * r_dwy;
        r_q     <= r_dvy * r_dwx;
        r_cross <= XW'(r_p) - XW'(r_q);
        if (i_cmd.area_clr) begin
            r_area <= '0;
        end else if (i_cmd.area_acc) begin
            r_area <= r_area + AW'(r_cross);
        end
    end

    // margin compares
    assign w_cross_ext = CMPW'(r_cross);
    assign w_cvx_ext   = $signed(CMPW'(i_convex_margin));
    assign w_ins_ext   = $signed(CMPW'(i_inside_margin));

    assign o_sts.x_done      = r_vld[2];
    assign o_sts.gt_convex   = w_cross_ext > w_cvx_ext;
    assign o_sts.gt_inside   = w_cross_ext > w_ins_ext;
    assign o_sts.area_neg    = r_area[AW-1];
    assign o_sts.p_is_corner = (r_ip == r_i0) || (r_ip == r_i1) || (r_ip == r_i2);

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_fan) begin
                o_corner_a <= i_cmd.fan_a;
                o_corner_b <= i_cmd.fan_b;
                o_corner_c <= i_cmd.fan_c;
            end else begin
                o_corner_a <= OUT_IDX_W'(r_tb_rd[3*IW-1:2*IW]);
                o_corner_b <= OUT_IDX_W'(r_tb_rd[2*IW-1:IW]);
                o_corner_c <= OUT_IDX_W'(r_tb_rd[IW-1:0]);
            end
            o_last_triangle <= i_cmd.out_last;
            o_used_fan      <= i_cmd.out_fan;
            o_truncated     <= i_cmd.out_trunc;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ect_ctrl.sv =====
`default_nettype none

module ect_ctrl #(
    parameter int MAX_VERTICES = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ect_pkg::t_cmd      o_cmd,
    input  wire ect_pkg::t_sts i_sts
);
    import ect_pkg::*;

    localparam int CNW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [5:0] {
        ST_IDLE, ST_START, ST_AR_RD0, ST_AR_RD1, ST_AR_W, ST_AR_X, ST_AR_XW, ST_AR_END,
        ST_INIT, ST_CHK, ST_C_RD0, ST_C_RD1, ST_C_RD2, ST_C_SB, ST_C_SC, ST_C_W, ST_C_X,
        ST_C_XW, ST_NEXT, ST_K_RD, ST_K_W, ST_K_CHK, ST_K_W2, ST_K_X, ST_K_XW, ST_K_NEXT,
        ST_EAR, ST_SH, ST_SH_WR, ST_F_RD0, ST_F_RD1, ST_F_RD2, ST_F_W, ST_F_WR,
        ST_EM_RD, ST_EM_LD, ST_EM_WT, ST_FAN_LD, ST_FAN_WT
    } t_state;

    t_state         r_state;
    logic [CNW-1:0] r_count, r_n, r_nv, r_w, r_i, r_k, r_j, r_cnt;
    logic           r_ovf, r_trunc, r_rev;
    logic [1:0]     r_xstep;

    logic           w_accept, w_stored, w_out_acc;
    logic [CNW-1:0] w_prev, w_next, w_nm1, w_nvm1;

    function automatic logic [CNW-1:0] f_orig(input logic [CNW-1:0] n,
                                              input logic rev, input logic [CNW-1:0] w);
        return rev ? (n - CNW'(1) - w) : w;
    endfunction

    assign o_in_ready = (r_state == ST_IDLE) && i_rst_n;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_stored   = r_count < CNW'(MAX_VERTICES);
    assign w_out_acc  = o_out_valid && i_out_ready;
    assign w_nm1      = r_n - CNW'(1);
    assign w_nvm1     = r_nv - CNW'(1);
    assign w_prev     = (r_i == '0) ? w_nvm1 : r_i - CNW'(1);
    assign w_next     = (r_i == w_nvm1) ? '0 : r_i + CNW'(1);

    // command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.st_asel   = AS_CTRL;
        o_cmd.cdst      = CD_NONE;
        o_cmd.xsel      = XS_ABC;
        o_cmd.rdst      = RD_NONE;
        o_cmd.out_trunc = r_trunc;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.st_we     = w_accept && w_stored;
                o_cmd.ctrl_addr = t_idx'(r_count);
            end
            ST_START: o_cmd.area_clr = 1'b1;
            ST_AR_RD0: begin
                o_cmd.ctrl_addr = t_idx'(r_w);
                o_cmd.cdst      = CD_B;
            end
            ST_AR_RD1: begin
                o_cmd.ctrl_addr = (r_w == w_nm1) ? '0 : t_idx'(r_w + CNW'(1));
                o_cmd.cdst      = CD_C;
            end
            ST_AR_X: begin
                o_cmd.x_start = 1'b1;
                o_cmd.xsel    = XS_AREA;
            end
            ST_AR_XW: o_cmd.area_acc = i_sts.x_done;
            ST_INIT: begin
                o_cmd.rl_we    = 1'b1;
                o_cmd.rl_waddr = t_idx'(r_w);
                o_cmd.rl_wdata = t_idx'(f_orig(r_n, r_rev, r_w));
            end
            ST_C_RD0: begin
                o_cmd.rl_raddr = t_idx'(w_prev);
                o_cmd.rdst     = RD_I0;
            end
            ST_C_RD1: begin
                o_cmd.rl_raddr = t_idx'(r_i);
                o_cmd.rdst     = RD_I1;
            end
            ST_C_RD2: begin
                o_cmd.rl_raddr = t_idx'(w_next);
                o_cmd.rdst     = RD_I2;
                o_cmd.st_asel  = AS_I0;
                o_cmd.cdst     = CD_A;
            end
            ST_C_SB: begin
                o_cmd.st_asel = AS_I1;
                o_cmd.cdst    = CD_B;
            end
            ST_C_SC: begin
                o_cmd.st_asel = AS_I2;
                o_cmd.cdst    = CD_C;
            end
            ST_C_X: o_cmd.x_start = 1'b1;
            ST_K_RD: begin
                o_cmd.rl_raddr = t_idx'(r_k);
                o_cmd.rdst     = RD_P;
            end
            ST_K_CHK: begin
                o_cmd.st_asel = AS_P;
                o_cmd.cdst    = i_sts.p_is_corner ? CD_NONE : CD_P;
            end
            ST_K_X: begin
                o_cmd.x_start = 1'b1;
                case (r_xstep)
                    2'd0:    o_cmd.xsel = XS_ABP;
                    2'd1:    o_cmd.xsel = XS_BCP;
                    default: o_cmd.xsel = XS_CAP;
                endcase
            end
            ST_EAR: begin
                o_cmd.tb_we   = 1'b1;
                o_cmd.tb_addr = t_idx'(r_cnt);
            end
            ST_SH: o_cmd.rl_raddr = t_idx'(r_j + CNW'(1));
            ST_SH_WR: begin
                o_cmd.rl_we    = 1'b1;
                o_cmd.rl_wsrc  = 1'b1;
                o_cmd.rl_waddr = t_idx'(r_j);
            end
            ST_F_RD0: begin
                o_cmd.rl_raddr = t_idx'(0);
                o_cmd.rdst     = RD_I0;
            end
            ST_F_RD1: begin
                o_cmd.rl_raddr = t_idx'(1);
                o_cmd.rdst     = RD_I1;
            end
            ST_F_RD2: begin
                o_cmd.rl_raddr = t_idx'(2);
                o_cmd.rdst     = RD_I2;
            end
            ST_F_WR: begin
                o_cmd.tb_we   = 1'b1;
                o_cmd.tb_addr = t_idx'(r_cnt);
            end
            ST_EM_RD: o_cmd.tb_addr = t_idx'(r_w);
            ST_EM_LD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = (r_w == r_cnt - CNW'(1));
            end
            ST_FAN_LD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_fan  = 1'b1;
                o_cmd.fan_a    = t_idx'(f_orig(r_n, r_rev, '0));
                o_cmd.fan_b    = t_idx'(f_orig(r_n, r_rev, r_w - CNW'(1)));
                o_cmd.fan_c    = t_idx'(f_orig(r_n, r_rev, r_w));
                o_cmd.out_last = (r_w == w_nm1);
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_trunc     <= 1'b0;
            r_rev       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_out_acc) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                // vertex loading
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_in_last) begin
                            r_n     <= w_stored ? r_count + CNW'(1) : r_count;
                            r_trunc <= r_ovf || !w_stored;
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= ST_START;
                        end else if (w_stored) begin
                            r_count <= r_count + CNW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                ST_START: begin
                    r_rev <= 1'b0;
                    r_w   <= '0;
                    if (r_n < CNW'(3)) begin
                        r_state <= ST_IDLE;
                    end else if (r_n == CNW'(3)) begin
                        r_state <= ST_INIT;
                    end else begin
                        r_state <= ST_AR_RD0;
                    end
                end
                // orientation from the signed area
                ST_AR_RD0: r_state <= ST_AR_RD1;
                ST_AR_RD1: r_state <= ST_AR_W;
                ST_AR_W:   r_state <= ST_AR_X;
                ST_AR_X:   r_state <= ST_AR_XW;
                ST_AR_XW: begin
                    if (i_sts.x_done) begin
                        if (r_w == w_nm1) begin
                            r_state <= ST_AR_END;
                        end else begin
                            r_w     <= r_w + CNW'(1);
                            r_state <= ST_AR_RD0;
                        end
                    end
                end
                ST_AR_END: begin
                    r_rev   <= i_sts.area_neg;
                    r_w     <= '0;
                    r_state <= ST_INIT;
                end
                // working list fill
                ST_INIT: begin
                    if (r_w == w_nm1) begin
                        r_nv    <= r_n;
                        r_cnt   <= '0;
                        r_state <= ST_CHK;
                    end else begin
                        r_w <= r_w + CNW'(1);
                    end
                end
                ST_CHK: begin
                    r_i     <= '0;
                    r_state <= (r_nv > CNW'(3)) ? ST_C_RD0 : ST_F_RD0;
                end
                // candidate ear fetch and convexity
                ST_C_RD0: r_state <= ST_C_RD1;
                ST_C_RD1: r_state <= ST_C_RD2;
                ST_C_RD2: r_state <= ST_C_SB;
                ST_C_SB:  r_state <= ST_C_SC;
                ST_C_SC:  r_state <= ST_C_W;
                ST_C_W:   r_state <= ST_C_X;
                ST_C_X:   r_state <= ST_C_XW;
                ST_C_XW: begin
                    if (i_sts.x_done) begin
                        r_k     <= '0;
                        r_state <= i_sts.gt_convex ? ST_K_RD : ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (r_i == w_nvm1) begin
                        r_w     <= CNW'(2);
                        r_state <= ST_FAN_LD;
                    end else begin
                        r_i     <= r_i + CNW'(1);
                        r_state <= ST_C_RD0;
                    end
                end
                // containment scan over remaining vertices
                ST_K_RD: r_state <= ST_K_W;
                ST_K_W:  r_state <= ST_K_CHK;
                ST_K_CHK: begin
                    r_xstep <= '0;
                    r_state <= i_sts.p_is_corner ? ST_K_NEXT : ST_K_W2;
                end
                ST_K_W2: r_state <= ST_K_X;
                ST_K_X:  r_state <= ST_K_XW;
                ST_K_XW: begin
                    if (i_sts.x_done) begin
                        if (!i_sts.gt_inside) begin
                            r_state <= ST_K_NEXT;
                        end else if (r_xstep == 2'd2) begin
                            r_state <= ST_NEXT;
                        end else begin
                            r_xstep <= r_xstep + 2'd1;
                            r_state <= ST_K_X;
                        end
                    end
                end
                ST_K_NEXT: begin
                    if (r_k == w_nvm1) begin
                        r_state <= ST_EAR;
                    end else begin
                        r_k     <= r_k + CNW'(1);
                        r_state <= ST_K_RD;
                    end
                end
                // clip the ear and close the gap in the list
                ST_EAR: begin
                    r_cnt   <= r_cnt + CNW'(1);
                    r_j     <= r_i;
                    r_state <= ST_SH;
                end
                ST_SH: begin
                    if (r_j == w_nvm1) begin
                        r_nv    <= w_nvm1;
                        r_state <= ST_CHK;
                    end else begin
                        r_state <= ST_SH_WR;
                    end
                end
                ST_SH_WR: begin
                    r_j     <= r_j + CNW'(1);
                    r_state <= ST_SH;
                end
                // final triangle
                ST_F_RD0: r_state <= ST_F_RD1;
                ST_F_RD1: r_state <= ST_F_RD2;
                ST_F_RD2: r_state <= ST_F_W;
                ST_F_W:   r_state <= ST_F_WR;
                ST_F_WR: begin
                    r_cnt   <= r_cnt + CNW'(1);
                    r_w     <= '0;
                    r_state <= ST_EM_RD;
                end
                // buffered triangles out
                ST_EM_RD: r_state <= ST_EM_LD;
                ST_EM_LD: begin
                    o_out_valid <= 1'b1;
                    r_state     <= ST_EM_WT;
                end
                ST_EM_WT: begin
                    if (w_out_acc) begin
                        if (r_w == r_cnt - CNW'(1)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_w     <= r_w + CNW'(1);
                            r_state <= ST_EM_RD;
                        end
                    end
                end
                // fan fallback out
                ST_FAN_LD: begin
                    o_out_valid <= 1'b1;
                    r_state     <= ST_FAN_WT;
                end
                ST_FAN_WT: begin
                    if (w_out_acc) begin
                        if (r_w == w_nm1) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_w     <= r_w + CNW'(1);
                            r_state <= ST_FAN_LD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/ear_clip_triangulator_unit.sv =====
// one vertex transaction per cycle while loading; the polygon closes on last_vertex
// triangulation runs on one shared cross product unit (difference, product and cross
// registers): orientation from the signed area, then the list fill, the convexity check
// per candidate ear, the containment scan over the other vertices, the list shift on a clip
// each triangle is loaded only after the one before it is accepted; no vertex is taken
// until all are out; synchronous active-low reset clears sequencer, vertex count, margins
`default_nettype none

module ear_clip_triangulator_unit #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ect_vtx_if.sink                              i_vtx,
    ect_tri_if.source                            o_tri,
    input  wire logic                            i_cfg_we,
    input  wire logic [ect_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ect_pkg::MARGIN_W-1:0]    i_cfg_data
);
    import ect_pkg::*;

    logic [MARGIN_W-1:0] r_convex_margin;
    logic [MARGIN_W-1:0] r_inside_margin;
    t_cmd                w_cmd;
    t_sts                w_sts;

    // margin registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_convex_margin <= '0;
            r_inside_margin <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CONVEX_MARGIN: r_convex_margin <= i_cfg_data;
                CFG_INSIDE_MARGIN: r_inside_margin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ect_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_vtx.valid),
        .i_in_last   (i_vtx.last_vertex),
        .o_in_ready  (i_vtx.ready),
        .o_out_valid (o_tri.valid),
        .i_out_ready (o_tri.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    ect_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_coord_x       (i_vtx.coord_x),
        .i_coord_y       (i_vtx.coord_y),
        .i_convex_margin (r_convex_margin),
        .i_inside_margin (r_inside_margin),
        .o_corner_a      (o_tri.corner_a),
        .o_corner_b      (o_tri.corner_b),
        .o_corner_c      (o_tri.corner_c),
        .o_last_triangle (o_tri.last_triangle),
        .o_used_fan      (o_tri.used_fan),
        .o_truncated     (o_tri.truncated)
    );

endmodule

`default_nettype wire

// ===== tb/ear_clip_triangulator_unit_tb.sv =====
`default_nettype none

// one expected triangle
typedef struct {
    bit [5:0] a;
    bit [5:0] b;
    bit [5:0] c;
    bit       last_tri;
    bit       fan;
    bit       trunc;
} t_tri_exp;

// polygon triangulation predictor and triangle checker
class t_tri_scoreboard;
    longint   vx[64];
    longint   vy[64];
    int       wlist[64];
    int       nstored;
    bit       dropped;
    longint   convex_m;
    longint   inside_m;
    bit       flipped;
    int       npoly;
    t_tri_exp tri_q[$];
    int       errors;

    function new();
        nstored = 0;
        dropped = 0;
        convex_m = 0;
        inside_m = 0;
        errors = 0;
    endfunction

    function int orig_idx(int w);
        return (flipped ? npoly - 1 - w : w) % 64;
    endfunction

    // doubled signed area of working triangle
    function longint area2(int a, int b, int c);
        int oa, ob, oc;
        oa = orig_idx(a);
        ob = orig_idx(b);
        oc = orig_idx(c);
        return (vx[ob] - vx[oa]) * (vy[oc] - vy[oa]) - (vy[ob] - vy[oa]) * (vx[oc] - vx[oa]);
    endfunction

    function void add_tri(ref t_tri_exp buf_q[$], input int a, input int b, input int c,
                          input bit fan);
        t_tri_exp t;
        t.a = 6'(orig_idx(a));
        t.b = 6'(orig_idx(b));
        t.c = 6'(orig_idx(c));
        t.last_tri = 0;
        t.fan = fan;
        t.trunc = dropped;
        buf_q.insert(buf_q.size(), t);
    endfunction

    function void triangulate();
        t_tri_exp res[$];
        longint   area;
        int       n, nv, i, k, j, i0, i1, i2, p;
        bit       found, empty;
        n = nstored;
        npoly = n;
        flipped = 0;
        if (n < 3) return;
        if (n == 3) begin
            add_tri(res, 0, 1, 2, 0);
        end else begin
            area = 0;
            for (i = 0; i < n; i++) begin
                j = (i + 1) % n;
                area += vx[i] * vy[j] - vx[j] * vy[i];
            end
            flipped = area < 0;
            for (i = 0; i < n; i++) wlist[i] = i;
            nv = n;
            // clip ears until a triangle is left or no ear is found
            while (nv > 3) begin
                found = 0;
                for (i = 0; i < nv && !found; i++) begin
                    i0 = wlist[(i + nv - 1) % nv];
                    i1 = wlist[i];
                    i2 = wlist[(i + 1) % nv];
                    empty = 1;
                    if (!(area2(i0, i1, i2) > convex_m)) continue;
                    for (k = 0; k < nv && empty; k++) begin
                        p = wlist[k];
                        if (p == i0 || p == i1 || p == i2) continue;
                        if (area2(i0, i1, p) > inside_m && area2(i1, i2, p) > inside_m &&
                            area2(i2, i0, p) > inside_m)
                            empty = 0;
                    end
                    if (!empty) continue;
                    add_tri(res, i0, i1, i2, 0);
                    for (k = i; k < nv - 1; k++) wlist[k] = wlist[k + 1];
                    nv--;
                    found = 1;
                end
                if (!found) break;
            end
            if (nv == 3) add_tri(res, wlist[0], wlist[1], wlist[2], 0);
            // fan fallback
            if (res.size() != n - 2) begin
                res.delete();
                for (i = 2; i < n; i++) add_tri(res, 0, i - 1, i, 1);
            end
        end
        res[res.size() - 1].last_tri = 1;
        tri_q = {tri_q, res};
    endfunction

    function void set_margin(logic [ect_pkg::CFG_IDX_W-1:0] idx,
                             logic [ect_pkg::MARGIN_W-1:0] val);
        if (idx == ect_pkg::CFG_CONVEX_MARGIN) convex_m = longint'(val);
        else if (idx == ect_pkg::CFG_INSIDE_MARGIN) inside_m = longint'(val);
    endfunction

    // accepted vertex transaction
    function void note_vertex(logic signed [15:0] x, logic signed [15:0] y, bit last);
        if (nstored < 64) begin
            vx[nstored] = longint'(x);
            vy[nstored] = longint'(y);
            nstored++;
        end else begin
            dropped = 1;
        end
        if (last) begin
            triangulate();
            nstored = 0;
            dropped = 0;
        end
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    // accepted triangle transaction
    task check_tri(bit [5:0] a, bit [5:0] b, bit [5:0] c, bit last_tri, bit fan, bit trunc);
        t_tri_exp e;
        if (tri_q.size() == 0) begin
            report($sformatf("unexpected triangle %0d %0d %0d", a, b, c));
            return;
        end
        e = tri_q.pop_front();
        if (a !== e.a) report($sformatf("corner_a %0d, expected %0d", a, e.a));
        if (b !== e.b) report($sformatf("corner_b %0d, expected %0d", b, e.b));
        if (c !== e.c) report($sformatf("corner_c %0d, expected %0d", c, e.c));
        if (last_tri !== e.last_tri)
            report($sformatf("last_triangle %0d, expected %0d", last_tri, e.last_tri));
        if (fan !== e.fan) report($sformatf("used_fan %0d, expected %0d", fan, e.fan));
        if (trunc !== e.trunc)
            report($sformatf("truncated %0d, expected %0d", trunc, e.trunc));
    endtask
endclass

module ear_clip_triangulator_unit_tb;
    import ect_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 6000000;
    localparam int DRAIN_WAIT = 400;
    localparam int HOLD_CYCLES = 400;

    typedef enum int {PK_STAR, PK_NOISE} t_poly_kind;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [MARGIN_W-1:0] i_cfg_data;

    ect_vtx_if #(.COORD_WIDTH(16)) vtx_ch ();
    ect_tri_if                     tri_ch ();

    t_tri_scoreboard sb;
    int            poly_x[$];
    int            poly_y[$];
    int            items_sent;
    int            idle_cycles;
    bit            hold_req;

    ear_clip_triangulator_unit #(.MAX_VERTICES(64), .COORD_WIDTH(16)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vtx      (vtx_ch.sink),
        .o_tri      (tri_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // result sink ready with short stalls, long stalls, bursts and a forced hold-off
    initial begin
        int r;
        tri_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (hold_req) begin
                tri_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
            end else if (r < 60) begin
                tri_ch.ready = 1'b1;
            end else if (r < 85) begin
                tri_ch.ready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else if (r < 92) begin
                tri_ch.ready = 1'b1;
                repeat ($urandom_range(20, 100)) @(negedge i_clk);
            end else begin
                tri_ch.ready = 1'b0;
                repeat ($urandom_range(10, 60)) @(negedge i_clk);
            end
        end
    end

    // triangle monitor
    always @(posedge i_clk) begin
        if (i_rst_n && tri_ch.valid && tri_ch.ready)
            sb.check_tri(tri_ch.corner_a, tri_ch.corner_b, tri_ch.corner_c,
                         tri_ch.last_triangle, tri_ch.used_fan, tri_ch.truncated);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((vtx_ch.valid && vtx_ch.ready) || (tri_ch.valid && tri_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [MARGIN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        sb.set_margin(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.tri_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_margins(logic [MARGIN_W-1:0] cm, logic [MARGIN_W-1:0] im);
        wait_drained();
        write_cfg(CFG_CONVEX_MARGIN, cm);
        write_cfg(CFG_INSIDE_MARGIN, im);
    endtask

    // one vertex transaction, then at times a random gap; valid always drops after a polygon
    task automatic send_vertex(int x, int y, bit last);
        int r;
        @(negedge i_clk);
        vtx_ch.valid = 1'b1;
        vtx_ch.coord_x = 16'(x);
        vtx_ch.coord_y = 16'(y);
        vtx_ch.last_vertex = last;
        do @(posedge i_clk); while (!vtx_ch.ready);
        sb.note_vertex(vtx_ch.coord_x, vtx_ch.coord_y, last);
        items_sent++;
        r = $urandom_range(0, 99);
        if (r >= 55 || last) begin
            @(negedge i_clk);
            vtx_ch.valid = 1'b0;
            if (r < 95) repeat ($urandom_range(0, 3)) @(negedge i_clk);
            else repeat ($urandom_range(10, 80)) @(negedge i_clk);
        end
    endtask

    task automatic send_poly();
        foreach (poly_x[i]) send_vertex(poly_x[i], poly_y[i], i == poly_x.size() - 1);
        poly_x.delete();
        poly_y.delete();
    endtask

    task automatic add_pt(int x, int y);
        poly_x.insert(poly_x.size(), x);
        poly_y.insert(poly_y.size(), y);
    endtask

    // star-shaped simple polygon or unstructured point noise
    task automatic make_poly(int n, t_poly_kind kind, int scale);
        real ang, step, rad;
        int  cx, cy, x, y, i;
        bit  cw;
        cw = $urandom_range(0, 1);
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        ang = 0.0;
        for (i = 0; i < n; i++) begin
            if (kind == PK_NOISE) begin
                x = $urandom_range(0, 65535) - 32768;
                y = $urandom_range(0, 65535) - 32768;
            end else begin
                step = 6.2831853 / n * (0.5 + $urandom_range(0, 100) / 100.0);
                ang = ang + (cw ? -step : step);
                rad = scale * (0.2 + $urandom_range(0, 80) / 100.0);
                x = cx + $rtoi(rad * $cos(ang));
                y = cy + $rtoi(rad * $sin(ang));
                if (x > 32767) x = 32767;
                if (x < -32768) x = -32768;
                if (y > 32767) y = 32767;
                if (y < -32768) y = -32768;
            end
            add_pt(x, y);
        end
    endtask

    task automatic random_phase(int count);
        int         stop_at, n, r;
        t_poly_kind kind;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 8) n = $urandom_range(1, 3);
            else if (r < 95) n = $urandom_range(4, 12);
            else n = $urandom_range(60, 68);
            kind = ($urandom_range(0, 99) < 80) ? PK_STAR : PK_NOISE;
            make_poly(n, kind, ($urandom_range(0, 3) == 0) ? 30000 : $urandom_range(8, 3000));
            send_poly();
            r = $urandom_range(0, 99);
            if (r < 5) hold_req = 1;
            else if (r < 12) while (sb.tri_q.size() != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        sb = new();
        items_sent = 0;
        idle_cycles = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_CONVEX_MARGIN;
        i_cfg_data = '0;
        vtx_ch.valid = 1'b0;
        vtx_ch.coord_x = '0;
        vtx_ch.coord_y = '0;
        vtx_ch.last_vertex = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // single and two-vertex polygons give nothing
        add_pt(-32768, 32767);
        send_poly();
        add_pt(32767, -32768); add_pt(0, 0);
        send_poly();
        // plain triangle
        add_pt(0, 0); add_pt(10, 0); add_pt(0, 10);
        send_poly();
        // long receiver hold-off while the following polygons keep coming
        hold_req = 1;
        // counter-clockwise and clockwise squares
        add_pt(0, 0); add_pt(100, 0); add_pt(100, 100); add_pt(0, 100);
        send_poly();
        add_pt(0, 0); add_pt(0, 100); add_pt(100, 100); add_pt(100, 0);
        send_poly();
        // concave arrow
        add_pt(0, 0); add_pt(50, 20); add_pt(100, 0); add_pt(50, 100); add_pt(50, 40);
        send_poly();
        // collinear points force the fan
        add_pt(0, 0); add_pt(1, 1); add_pt(2, 2); add_pt(3, 3);
        send_poly();
        // full-range square
        add_pt(-32768, -32768); add_pt(32767, -32768); add_pt(32767, 32767);
        add_pt(-32768, 32767);
        send_poly();

        random_phase(80);
        set_margins(20'hFFFFF, 20'hFFFFF);
        add_pt(-32768, -32768); add_pt(32767, -32768); add_pt(32767, 32767);
        add_pt(-32768, 32767);
        send_poly();
        random_phase(50);
        set_margins(20'($urandom_range(0, 5000)), 20'($urandom_range(0, 5000)));
        random_phase(80);
        set_margins(20'd0, 20'hFFFFF);
        random_phase(50);
        set_margins(20'hFFFFF, 20'd0);
        // overflow polygon: more vertices than capacity
        make_poly(66, PK_STAR, 30000);
        send_poly();
        random_phase(50);

        @(negedge i_clk);
        vtx_ch.valid = 1'b0;
        while (sb.tri_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

`default_nettype wire
